FILE: rtl/esc_telemetry_frame_parser_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ESC telemetry frame parser
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ESC_TELEMETRY_FRAME_PARSER_ASSERT_SVH
`define ESC_TELEMETRY_FRAME_PARSER_ASSERT_SVH

// Same-cycle implication
`define ESCTFP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ESCTFP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/esctfp_pkg.sv
// ----------------------------------------------------------------------------
// esctfp_pkg
// Shared types, frame layout constants and the CRC-16/MODBUS byte update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package esctfp_pkg;

    localparam int FRAME_BYTES = 32;
    localparam int POS_W       = $clog2(FRAME_BYTES);

    localparam logic [7:0]  START_BYTE   = 8'hFE;
    localparam logic [31:0] CONTROL_WORD = 32'h3003_0001;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY_REF = 16'hA001;

    // Byte positions inside a frame
    localparam logic [POS_W-1:0] POS_HUNT      = POS_W'(0);
    localparam logic [POS_W-1:0] POS_CTL_FIRST = POS_W'(1);
    localparam logic [POS_W-1:0] POS_CTL_LAST  = POS_W'(4);
    localparam logic [POS_W-1:0] POS_THR_IN    = POS_W'(9);
    localparam logic [POS_W-1:0] POS_THR_OUT   = POS_W'(10);
    localparam logic [POS_W-1:0] POS_DIR       = POS_W'(11);
    localparam logic [POS_W-1:0] POS_RPM_LO    = POS_W'(13);
    localparam logic [POS_W-1:0] POS_RPM_HI    = POS_W'(14);
    localparam logic [POS_W-1:0] POS_VOLT      = POS_W'(15);
    localparam logic [POS_W-1:0] POS_ESC_TEMP  = POS_W'(19);
    localparam logic [POS_W-1:0] POS_MOT_TEMP  = POS_W'(21);
    localparam logic [POS_W-1:0] POS_CRC_LO    = POS_W'(FRAME_BYTES - 2);
    localparam logic [POS_W-1:0] POS_CRC_HI    = POS_W'(FRAME_BYTES - 1);

    // Declared high field first so throttle_in lands in the lowest bits
    typedef struct packed {
        logic [7:0]  motor_temp;
        logic [7:0]  esc_temp;
        logic [7:0]  voltage_tenths;
        logic [15:0] rpm_raw;
        logic [7:0]  direction;
        logic [7:0]  throttle_out;
        logic [7:0]  throttle_in;
    } tlm_fields_t;

    typedef struct packed {
        logic        valid;
        logic        frame_ok;
        tlm_fields_t fields;
    } tlm_result_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY_REF;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // Expected control word byte at frame positions one to four
    function automatic logic [7:0] ctl_byte(input logic [POS_W-1:0] pos);
        logic [7:0] w;
        case (pos)
            POS_W'(1): w = CONTROL_WORD[7:0];
            POS_W'(2): w = CONTROL_WORD[15:8];
            POS_W'(3): w = CONTROL_WORD[23:16];
            default:   w = CONTROL_WORD[31:24];
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/esctfp_frame.sv
// ----------------------------------------------------------------------------
// esctfp_frame
// Frame tracker: start hunt, byte position, running CRC, control word check,
// field capture and the last-good-value store. One byte per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "esc_telemetry_frame_parser_assert.svh"

module esctfp_frame (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    step,
    input  wire logic [7:0]              rx_byte,
    output esctfp_pkg::tlm_result_t      result
);
    import esctfp_pkg::*;

    logic [POS_W-1:0] pos_reg,    pos_next;
    logic [15:0]      crc_reg,    crc_next;
    logic             ctl_ok_reg, ctl_ok_next;
    logic [7:0]       ck_lo_reg,  ck_lo_next;
    tlm_fields_t      pend_reg,   pend_next;
    tlm_fields_t      kept_reg,   kept_next;
    logic             good;

    always_comb
    begin
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        ctl_ok_next = ctl_ok_reg;
        ck_lo_next  = ck_lo_reg;
        pend_next   = pend_reg;
        kept_next   = kept_reg;
        good        = ctl_ok_reg && ({rx_byte, ck_lo_reg} == crc_reg);
        result      = '0;

        if (step)
        begin
            if (pos_reg == POS_HUNT)
            begin
                // drop everything but the start byte
                if (rx_byte == START_BYTE)
                begin
                    crc_next    = crc_byte(CRC_INIT, rx_byte);
                    ctl_ok_next = 1'b1;
                    pend_next   = '0;
                    pos_next    = POS_CTL_FIRST;
                end
            end
            else if (pos_reg < POS_CRC_LO)
            begin
                crc_next = crc_byte(crc_reg, rx_byte);
                if (pos_reg <= POS_CTL_LAST && rx_byte != ctl_byte(pos_reg))
                    ctl_ok_next = 1'b0;
                case (pos_reg)
                    POS_THR_IN:   pend_next.throttle_in    = rx_byte;
                    POS_THR_OUT:  pend_next.throttle_out   = rx_byte;
                    POS_DIR:      pend_next.direction      = rx_byte;
                    POS_RPM_LO:   pend_next.rpm_raw[7:0]   = rx_byte;
                    POS_RPM_HI:   pend_next.rpm_raw[15:8]  = rx_byte;
                    POS_VOLT:     pend_next.voltage_tenths = rx_byte;
                    POS_ESC_TEMP: pend_next.esc_temp       = rx_byte;
                    POS_MOT_TEMP: pend_next.motor_temp     = rx_byte;
                    default:      ;
                endcase
                pos_next = pos_reg + POS_W'(1);
            end
            else if (pos_reg == POS_CRC_LO)
            begin
                ck_lo_next = rx_byte;
                pos_next   = POS_CRC_HI;
            end
            else
            begin
                if (good)
                    kept_next = pend_reg;
                else
                begin
                    kept_next.throttle_in  = '0;
                    kept_next.throttle_out = '0;
                    kept_next.direction    = '0;
                    kept_next.rpm_raw      = '0;
                end
                pos_next        = POS_HUNT;
                crc_next        = CRC_INIT;
                ctl_ok_next     = 1'b1;
                result.valid    = 1'b1;
                result.frame_ok = good;
            end
        end
        result.fields = kept_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= POS_HUNT;
            crc_reg    <= CRC_INIT;
            ctl_ok_reg <= 1'b1;
            ck_lo_reg  <= '0;
            pend_reg   <= '0;
            kept_reg   <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            crc_reg    <= crc_next;
            ctl_ok_reg <= ctl_ok_next;
            ck_lo_reg  <= ck_lo_next;
            pend_reg   <= pend_next;
            kept_reg   <= kept_next;
        end
    end

    `ESCTFP_ASSERT_NXT(a_hunt_holds,
        step && pos_reg == POS_HUNT && rx_byte != START_BYTE,
        pos_reg == POS_HUNT, "non-start byte left the hunt state")
    `ESCTFP_ASSERT_IMP(a_result_on_last,
        result.valid, step && pos_reg == POS_CRC_HI, "result outside last frame byte")
    `ESCTFP_ASSERT_NXT(a_rearm_after_frame,
        step && pos_reg == POS_CRC_HI,
        pos_reg == POS_HUNT && crc_reg == CRC_INIT && ctl_ok_reg, "parser not rearmed")

endmodule

`default_nettype wire

FILE: rtl/esc_telemetry_frame_parser.sv
// ----------------------------------------------------------------------------
// esc_telemetry_frame_parser
// Parses 32-byte ESC telemetry frames from a byte stream and reports each one.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side (s_tvalid/s_tready/s_tdata) takes one received byte per word.
//   Outside a frame, bytes other than 0xFE are dropped; 0xFE opens a frame
//   of 32 bytes that is never resynchronized partway through.
//   Master side (m_tvalid/m_tready/m_tdata/m_tuser) carries one word per
//   completed frame: m_tuser is frame_ok, m_tdata the telemetry fields.
//   A rejected frame reports zero throttle, direction and rpm, and repeats
//   voltage and temperatures from the last good frame.
//   Path: the last frame byte passes through the input register, then the
//   result register, before the result word appears.
//   Throughput: one byte per cycle unless a stall holds the input; the CRC
//   update and field capture sit in one stage between input and result regs.
//   Stall: while a result word waits on m_tready, the input register holds
//   and s_tready drops once it is full.
//   Reset: hunting for a start byte, CRC 0xFFFF, all last-good values zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "esc_telemetry_frame_parser_assert.svh"

module esc_telemetry_frame_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [7:0] throttle_in, [15:8] throttle_out,
                                        // [23:16] direction, [39:24] rpm_raw,
                                        // [47:40] voltage_tenths, [55:48] esc_temp,
                                        // [63:56] motor_temp
    output logic             m_tuser    // [0] frame_ok
);
    import esctfp_pkg::*;

    logic        in_vld_reg;
    logic [7:0]  in_byte_reg;
    logic        out_vld_reg;
    tlm_fields_t out_data_reg;
    logic        out_ok_reg;
    logic        out_free;
    logic        step;
    tlm_result_t res;

    assign out_free = !out_vld_reg || m_tready;
    assign step     = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || out_free;

    esctfp_frame u_frame (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (in_byte_reg),
        .result  (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_vld_reg <= s_tvalid;
            if (out_free)
                out_vld_reg <= res.valid;
        end
    end

    // payload: load on handshake, hold otherwise
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_byte_reg <= s_tdata;
        if (out_free && res.valid)
        begin
            out_data_reg <= res.fields;
            out_ok_reg   <= res.frame_ok;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_ok_reg;

    `ESCTFP_ASSERT_IMP(a_reject_clears,
        m_tvalid && !m_tuser, m_tdata[39:0] == 40'd0, "rejected frame kept live fields")
    `ESCTFP_ASSERT_NXT(a_stall_holds_input,
        in_vld_reg && !out_free, in_vld_reg && $stable(in_byte_reg), "input lost in stall")
    `ESCTFP_ASSERT_IMP(a_ready_when_empty,
        !in_vld_reg, s_tready, "ready low with empty input register")

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// ESC telemetry frame parser testbench
// Feeds byte streams of framed telemetry (good frames, control word and
// checksum faults, noise between frames) and checks each result word
// against a cycle-free predictor, under several source and sink stall mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import esctfp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_BYTES   = 1500;

    typedef enum int {FLAW_NONE, FLAW_CTL, FLAW_CRC_LO, FLAW_CRC_HI} frame_flaw_e;

    typedef struct packed {
        logic        frame_ok;
        tlm_fields_t fields;
    } telemetry_report_t;

    class telemetry_scoreboard;
        int                 frame_pos;
        logic [15:0]        crc;
        logic               ctl_match;
        logic [7:0]         crc_lo;
        tlm_fields_t        captured;
        tlm_fields_t        held;
        telemetry_report_t  expected_reports[$];
        int                 mismatches;

        function new();
            frame_pos  = 0;
            crc        = CRC_INIT;
            ctl_match  = 1'b1;
            crc_lo     = '0;
            captured   = '0;
            held       = '0;
            mismatches = 0;
        endfunction

        static function logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
            logic [15:0] c;
            c = acc ^ {8'h00, b};
            repeat (8)
            begin
                c = (c >> 1) ^ (c[0] ? CRC_POLY_REF : 16'h0000);
            end
            return c;
        endfunction

        // Advance the predictor by one accepted byte
        function void note_byte(input logic [7:0] b);
            logic good;
            if (frame_pos == 0)
            begin
                if (b == START_BYTE)
                begin
                    crc       = crc_step(CRC_INIT, b);
                    ctl_match = 1'b1;
                    captured  = '0;
                    frame_pos = 1;
                end
                return;
            end
            if (frame_pos < FRAME_BYTES - 2)
            begin
                crc = crc_step(crc, b);
                if (frame_pos >= POS_CTL_FIRST && frame_pos <= POS_CTL_LAST)
                    if (b != CONTROL_WORD[8*(frame_pos-1) +: 8])
                        ctl_match = 1'b0;
                case (frame_pos)
                    POS_THR_IN:   captured.throttle_in    = b;
                    POS_THR_OUT:  captured.throttle_out   = b;
                    POS_DIR:      captured.direction      = b;
                    POS_RPM_LO:   captured.rpm_raw[7:0]   = b;
                    POS_RPM_HI:   captured.rpm_raw[15:8]  = b;
                    POS_VOLT:     captured.voltage_tenths = b;
                    POS_ESC_TEMP: captured.esc_temp       = b;
                    POS_MOT_TEMP: captured.motor_temp     = b;
                    default: ;
                endcase
                frame_pos++;
                return;
            end
            if (frame_pos == POS_CRC_LO)
            begin
                crc_lo = b;
                frame_pos++;
                return;
            end
            good = ctl_match && ({b, crc_lo} == crc);
            if (good)
                held = captured;
            else
            begin
                held.throttle_in  = '0;
                held.throttle_out = '0;
                held.direction    = '0;
                held.rpm_raw      = '0;
            end
            frame_pos = 0;
            crc       = CRC_INIT;
            ctl_match = 1'b1;
            expected_reports.push_back({good, held});
        endfunction

        function void compare_field(input string name, input logic [15:0] want,
                                    input logic [15:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_report(input logic ok, input logic [63:0] data);
            telemetry_report_t want;
            tlm_fields_t       got;
            got = data;
            if (expected_reports.size() == 0)
            begin
                $error("result word with nothing pending: frame_ok %0h data %h", ok, data);
                mismatches++;
                return;
            end
            want = expected_reports.pop_front();
            compare_field("frame_ok",       16'(want.frame_ok),              16'(ok));
            compare_field("throttle_in",    16'(want.fields.throttle_in),    16'(got.throttle_in));
            compare_field("throttle_out",   16'(want.fields.throttle_out),   16'(got.throttle_out));
            compare_field("direction",      16'(want.fields.direction),      16'(got.direction));
            compare_field("rpm_raw",        want.fields.rpm_raw,             got.rpm_raw);
            compare_field("voltage_tenths", 16'(want.fields.voltage_tenths), 16'(got.voltage_tenths));
            compare_field("esc_temp",       16'(want.fields.esc_temp),       16'(got.esc_temp));
            compare_field("motor_temp",     16'(want.fields.motor_temp),     16'(got.motor_temp));
        endfunction

        function int pending_reports();
            return expected_reports.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tuser;

    telemetry_scoreboard sb;
    int send_idle_pct;
    int sink_stall_pct;
    int bytes_sent;
    int quiet_cycles;

    esc_telemetry_frame_parser dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_report(m_tuser, m_tdata);
    end

    // End the run when nothing moves on either side for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("esc_telemetry_frame_parser verification failed");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    // fill < 0 gives random payload, otherwise every payload byte is fill
    task automatic send_frame(input int fill, input frame_flaw_e flaw);
        logic [7:0]  frame [FRAME_BYTES];
        logic [15:0] crc;
        int          k;
        frame[0] = START_BYTE;
        for (int i = 1; i <= 4; i++)
            frame[i] = CONTROL_WORD[8*(i-1) +: 8];
        for (int i = 5; i < FRAME_BYTES - 2; i++)
            frame[i] = (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
        if (flaw == FLAW_CTL)
        begin
            k = $urandom_range(1, 4);
            frame[k] = frame[k] ^ 8'($urandom_range(1, 255));
        end
        crc = CRC_INIT;
        for (int i = 0; i < FRAME_BYTES - 2; i++)
            crc = telemetry_scoreboard::crc_step(crc, frame[i]);
        frame[FRAME_BYTES-2] = crc[7:0];
        frame[FRAME_BYTES-1] = crc[15:8];
        if (flaw == FLAW_CRC_LO)
            frame[FRAME_BYTES-2] = frame[FRAME_BYTES-2] ^ 8'($urandom_range(1, 255));
        if (flaw == FLAW_CRC_HI)
            frame[FRAME_BYTES-1] = frame[FRAME_BYTES-1] ^ 8'($urandom_range(1, 255));
        for (int i = 0; i < FRAME_BYTES; i++)
            send_byte(frame[i]);
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct, input int nbytes);
        int          stop_at;
        int          r;
        logic [7:0]  noise;
        frame_flaw_e flaw;
        send_idle_pct  = idle_pct;
        sink_stall_pct = stall_pct;
        stop_at        = bytes_sent + nbytes;
        while (bytes_sent < stop_at)
        begin
            // Line noise between frames, kept clear of the start byte
            repeat ($urandom_range(0, 3))
            begin
                noise = 8'($urandom_range(255));
                if (noise == START_BYTE)
                    noise = 8'h00;
                send_byte(noise);
            end
            r = $urandom_range(99);
            if (r < 70)
                flaw = FLAW_NONE;
            else if (r < 80)
                flaw = FLAW_CTL;
            else if (r < 90)
                flaw = FLAW_CRC_LO;
            else
                flaw = FLAW_CRC_HI;
            send_frame(-1, flaw);
        end
    endtask

    initial
    begin
        sb             = new();
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        bytes_sent     = 0;
        quiet_cycles   = 0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Dropped while hunting
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'h7F);
        // Rejected before any good frame: everything stays zero
        send_frame(8'hFF, FLAW_CRC_LO);
        send_frame(8'h00, FLAW_NONE);
        send_frame(8'hFF, FLAW_NONE);
        // Rejects keep voltage and temperatures of the last good frame
        send_frame(-1, FLAW_CTL);
        send_frame(-1, FLAW_CRC_HI);
        // Start byte inside a frame is plain data
        send_frame(START_BYTE, FLAW_NONE);

        run_random_phase(0,  0,  RANDOM_BYTES / 4);
        run_random_phase(55, 0,  RANDOM_BYTES / 4);
        run_random_phase(0,  55, RANDOM_BYTES / 4);
        run_random_phase(35, 35, RANDOM_BYTES / 4);

        s_tvalid       <= 1'b0;
        sink_stall_pct = 0;
        while (sb.pending_reports() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (sb.mismatches == 0)
            $display("esc_telemetry_frame_parser verification clean");
        else
            $display("esc_telemetry_frame_parser verification failed");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/esctfp_pkg.sv
rtl/esctfp_frame.sv
rtl/esc_telemetry_frame_parser.sv
tb/sv/testbench.sv
